[design/ecl2eq_pkg.sv]
package ecl2eq_pkg;

  localparam int ANGLE_W = 32;
  localparam int STAGES  = 28;
  localparam int DW      = 36;
  localparam int ZW      = 34;
  localparam int QSHIFT  = 30;

  typedef logic signed [DW-1:0]   dat_t;
  typedef logic signed [ZW-1:0]   ang_t;
  typedef logic signed [2*DW-1:0] prod_t;

  localparam dat_t GAIN_INV = 36'sd652032874;
  localparam dat_t SIN_EPS  = 36'sd427109969;
  localparam dat_t COS_EPS  = 36'sd985138863;
  localparam ang_t QUARTER  = 34'sd1073741824;
  localparam ang_t HALF     = 34'sd2147483648;

  // atan(2^-i) in binary angle units, one full turn is 2^32
  function automatic ang_t atan_tab(input int i);
    ang_t r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/ecl2eq_if.sv]
interface ecl2eq_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] ecl_longitude;
  logic signed [31:0] ecl_latitude;

  modport source (output valid, output ecl_longitude, output ecl_latitude, input ready);
  modport sink   (input valid, input ecl_longitude, input ecl_latitude, output ready);
endinterface

interface ecl2eq_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] right_ascension;
  logic signed [31:0] declination;

  modport source (output valid, output right_ascension, output declination, input ready);
  modport sink   (input valid, input right_ascension, input declination, output ready);
endinterface

[design/ecliptic_to_equatorial_j2000.sv]
// Ecliptic to J2000 equatorial converter. Angles are binary angles with 2^32
// per turn. Fully pipelined: one transaction is accepted every cycle while the
// output is not stalled. The stages are, in order, the sine/cosine CORDIC, the
// obliquity rotation multipliers, the right ascension CORDIC, gain correction,
// the declination CORDIC and an output register. A stall on the output
// freezes the whole pipeline; nothing is dropped or repeated.
// At the pole right ascension is 0; declination saturates at +/-90 degrees.
module ecliptic_to_equatorial_j2000 (
  input  logic         clk,
  input  logic         rst,
  ecl2eq_in_if.sink    ecl,
  ecl2eq_out_if.source eq
);
  import ecl2eq_pkg::*;

  logic adv;
  logic va, vb, vx, vr, vg, vd, vo;
  dat_t sa, ca, sb, cb;
  dat_t xq, yq, zq;
  dat_t rg, zq_r;
  ang_t ra_z, dec_z;
  logic pole, pole_d;
  logic [DW-1:0] zq_side;
  dat_t r, g_zq;
  logic [ANGLE_W-1:0] g_ra, ra_d;
  prod_t rk;
  dat_t r_scaled;
  logic [ANGLE_W-1:0] ra_out;
  logic signed [ANGLE_W-1:0] dec_out;

  assign adv       = !vo || eq.ready;
  assign ecl.ready = adv;

  ecl2eq_rot u_rot_lon (
    .clk, .rst, .en(adv), .in_valid(ecl.valid), .ang(ecl.ecl_longitude),
    .out_valid(va), .sin_o(sa), .cos_o(ca)
  );

  ecl2eq_rot u_rot_lat (
    .clk, .rst, .en(adv), .in_valid(ecl.valid), .ang(ecl.ecl_latitude),
    .out_valid(vb), .sin_o(sb), .cos_o(cb)
  );

  ecl2eq_xform u_xform (
    .clk, .rst, .en(adv), .in_valid(va && vb),
    .sa, .ca, .sb, .cb,
    .out_valid(vx), .xq, .yq, .zq
  );

  ecl2eq_vec #(.SW(DW)) u_vec_ra (
    .clk, .rst, .en(adv), .in_valid(vx),
    .x_in(xq), .y_in(yq), .zero_in(xq == 0 && yq == 0), .side_in(zq),
    .out_valid(vr), .mag(rg), .ang(ra_z), .zero_out(pole), .side_out(zq_side)
  );

  assign zq_r     = dat_t'(zq_side);
  assign rk       = prod_t'(rg) * prod_t'(GAIN_INV);
  assign r_scaled = dat_t'(rk >>> QSHIFT);

  // remove the CORDIC gain from the equatorial radius, clamp at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_zq <= zq_r;
      g_ra <= pole ? '0 : ra_z[ANGLE_W-1:0];
      if (pole || r_scaled < 0) begin
        r <= '0;
      end else begin
        r <= r_scaled;
      end
    end
  end

  ecl2eq_vec #(.SW(ANGLE_W)) u_vec_dec (
    .clk, .rst, .en(adv), .in_valid(vg),
    .x_in(r), .y_in(g_zq), .zero_in(r == 0 && g_zq == 0), .side_in(g_ra),
    .out_valid(vd), .mag(), .ang(dec_z), .zero_out(pole_d), .side_out(ra_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra_out <= ra_d;
      if (pole_d) begin
        dec_out <= '0;
      end else if (dec_z > QUARTER) begin
        dec_out <= QUARTER[ANGLE_W-1:0];
      end else if (dec_z < -QUARTER) begin
        dec_out <= ANGLE_W'(-QUARTER);
      end else begin
        dec_out <= dec_z[ANGLE_W-1:0];
      end
    end
  end

  assign eq.valid           = vo;
  assign eq.right_ascension = ra_out;
  assign eq.declination     = dec_out;

endmodule

[design/ecl2eq_rot.sv]
module ecl2eq_rot (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ecl2eq_pkg::ANGLE_W-1:0] ang,
  output logic                        out_valid,
  output ecl2eq_pkg::dat_t            sin_o,
  output ecl2eq_pkg::dat_t            cos_o
);
  import ecl2eq_pkg::*;

  dat_t x [0:STAGES];
  dat_t y [0:STAGES];
  ang_t z [0:STAGES];
  logic [STAGES:0] neg;
  logic [STAGES:0] v;
  ang_t z_in;

  assign z_in = ang_t'($signed(ang));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:0], in_valid};
    end
  end

  // fold into -90..90 degrees, flip the result at the end
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GAIN_INV;
      y[0] <= '0;
      if (z_in > QUARTER) begin
        z[0]   <= z_in - HALF;
        neg[0] <= 1'b1;
      end else if (z_in < -QUARTER) begin
        z[0]   <= z_in + HALF;
        neg[0] <= 1'b1;
      end else begin
        z[0]   <= z_in;
        neg[0] <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    localparam ang_t STEP = atan_tab(g);
    always_ff @(posedge clk) begin
      if (en) begin
        neg[g+1] <= neg[g];
        if (z[g] >= 0) begin
          x[g+1] <= x[g] - (y[g] >>> g);
          y[g+1] <= y[g] + (x[g] >>> g);
          z[g+1] <= z[g] - STEP;
        end else begin
          x[g+1] <= x[g] + (y[g] >>> g);
          y[g+1] <= y[g] - (x[g] >>> g);
          z[g+1] <= z[g] + STEP;
        end
      end
    end
  end

  assign out_valid = v[STAGES];
  assign sin_o     = neg[STAGES] ? -y[STAGES] : y[STAGES];
  assign cos_o     = neg[STAGES] ? -x[STAGES] : x[STAGES];

endmodule

[design/ecl2eq_xform.sv]
module ecl2eq_xform (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ecl2eq_pkg::dat_t sa,
  input  ecl2eq_pkg::dat_t ca,
  input  ecl2eq_pkg::dat_t sb,
  input  ecl2eq_pkg::dat_t cb,
  output logic             out_valid,
  output ecl2eq_pkg::dat_t xq,
  output ecl2eq_pkg::dat_t yq,
  output ecl2eq_pkg::dat_t zq
);
  import ecl2eq_pkg::*;

  logic [2:0] v;
  prod_t m_p, m_x;
  dat_t  p1, x1, sb1, x2;
  prod_t pc, ps, sbs, sbc;
  prod_t ydiff, zsum;

  assign m_p   = prod_t'(cb) * prod_t'(sa);
  assign m_x   = prod_t'(cb) * prod_t'(ca);
  assign ydiff = pc - sbs;
  assign zsum  = ps + sbc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= dat_t'(m_p >>> QSHIFT);
      x1  <= dat_t'(m_x >>> QSHIFT);
      sb1 <= sb;
      // rotate about x by the obliquity
      pc  <= prod_t'(COS_EPS) * prod_t'(p1);
      ps  <= prod_t'(SIN_EPS) * prod_t'(p1);
      sbs <= prod_t'(SIN_EPS) * prod_t'(sb1);
      sbc <= prod_t'(COS_EPS) * prod_t'(sb1);
      x2  <= x1;
      xq  <= x2;
      yq  <= dat_t'(ydiff >>> QSHIFT);
      zq  <= dat_t'(zsum >>> QSHIFT);
    end
  end

  assign out_valid = v[2];

endmodule

[design/ecl2eq_vec.sv]
module ecl2eq_vec #(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ecl2eq_pkg::dat_t x_in,
  input  ecl2eq_pkg::dat_t y_in,
  input  logic             zero_in,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output ecl2eq_pkg::dat_t mag,
  output ecl2eq_pkg::ang_t ang,
  output logic             zero_out,
  output logic [SW-1:0]    side_out
);
  import ecl2eq_pkg::*;

  dat_t x [0:STAGES];
  dat_t y [0:STAGES];
  ang_t z [0:STAGES];
  logic [SW-1:0] sd [0:STAGES];
  logic [STAGES:0] zf;
  logic [STAGES:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-1:0], in_valid};
    end
  end

  // pre-rotate by a half turn when x is negative
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= zero_in;
      sd[0] <= side_in;
      if (x_in < 0) begin
        x[0] <= -x_in;
        y[0] <= -y_in;
        z[0] <= HALF;
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    localparam ang_t STEP = atan_tab(g);
    always_ff @(posedge clk) begin
      if (en) begin
        zf[g+1] <= zf[g];
        sd[g+1] <= sd[g];
        if (y[g] > 0) begin
          x[g+1] <= x[g] + (y[g] >>> g);
          y[g+1] <= y[g] - (x[g] >>> g);
          z[g+1] <= z[g] + STEP;
        end else begin
          x[g+1] <= x[g] - (y[g] >>> g);
          y[g+1] <= y[g] + (x[g] >>> g);
          z[g+1] <= z[g] - STEP;
        end
      end
    end
  end

  assign out_valid = v[STAGES];
  assign mag       = x[STAGES];
  assign ang       = z[STAGES];
  assign zero_out  = zf[STAGES];
  assign side_out  = sd[STAGES];

endmodule

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ecl2eq_pkg::*;

  localparam int  PIPE_DEPTH  = 92;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  N_STEPS     = 28;
  localparam longint SIN_OBL  = 427109969;
  localparam longint COS_OBL  = 985138863;
  localparam longint K_INV    = 652032874;
  localparam logic [63:0] INV_2PI_Q64 = 64'h28BE60DB9391054A;

  typedef struct packed {
    logic        [31:0] ra;
    logic signed [31:0] dec;
  } radec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ecl2eq_in_if  ecl_ch ();
  ecl2eq_out_if eq_ch ();

  ecliptic_to_equatorial_j2000 uut (
    .clk (clk),
    .rst (rst),
    .ecl (ecl_ch.sink),
    .eq  (eq_ch.source)
  );

  always #10 clk = ~clk;

  longint atan_turns [N_STEPS];
  radec_t pending_radec [$];
  int     errors      = 0;
  int     cycles      = 0;
  bit     send_gaps   = 1'b1;
  bit     recv_stalls = 1'b1;
  int     hold_request = 0;

  // atan(2^-i) in binary angle units from a Q62 series scaled by 1/(2 pi)
  function automatic void build_atan_turns();
    logic [63:0]  rad, term;
    logic [127:0] wide;
    for (int i = 0; i < N_STEPS; i++) begin
      if (i == 0) begin
        atan_turns[i] = longint'(64'd1 << 29);
      end else begin
        rad = '0;
        for (int k = 0; i * (2 * k + 1) <= 61; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
          if (k % 2 == 1) rad = rad - term;
          else rad = rad + term;
        end
        wide = {64'd0, rad} * {64'd0, INV_2PI_Q64};
        atan_turns[i] = longint'((wide[127:64] + (64'd1 << 29)) >> 30);
      end
    end
  endfunction

  function automatic void rotate_sin_cos(input logic [31:0] ang, output longint s,
                                         output longint c);
    longint z, x, y, xs, ys;
    bit     flip;
    z = longint'({32'd0, ang});
    x = K_INV;
    y = 0;
    flip = 1'b0;
    if (z >= (64'sd1 <<< 31)) z = z - (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      flip = 1'b1;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_turns[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_turns[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_angle(input longint y_in, input longint x_in,
                                          output longint mag);
    longint x, y, z, xs, ys;
    x = x_in;
    y = y_in;
    z = 0;
    // fold the left half plane onto the right with a half turn
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 <<< 31;
    end
    for (int i = 0; i < N_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_turns[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_turns[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic radec_t equatorial_of(input logic [31:0] lon, input logic [31:0] lat);
    longint sa, ca, sb, cb, p, xq, yq, zq, rg, r, ra, dec, unused;
    radec_t res;
    rotate_sin_cos(lon, sa, ca);
    rotate_sin_cos(lat, sb, cb);
    p  = (cb * sa) >>> 30;
    xq = (cb * ca) >>> 30;
    yq = (COS_OBL * p - SIN_OBL * sb) >>> 30;
    zq = (SIN_OBL * p + COS_OBL * sb) >>> 30;
    if (xq == 0 && yq == 0) begin
      ra = 0; rg = 0;
    end else begin
      ra = vector_angle(yq, xq, rg);
    end
    r = (rg * K_INV) >>> 30;
    if (r < 0) r = 0;
    if (r == 0 && zq == 0) dec = 0;
    else dec = vector_angle(zq, r, unused);
    if (dec > (64'sd1 <<< 30)) dec = 64'sd1 <<< 30;
    if (dec < -(64'sd1 <<< 30)) dec = -(64'sd1 <<< 30);
    res.ra  = ra[31:0];
    res.dec = dec[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // caller is at a falling edge; valid stays high for back-to-back transactions
  task automatic send_direction(input logic [31:0] lon, input logic [31:0] lat);
    ecl_ch.valid         <= 1'b1;
    ecl_ch.ecl_longitude <= lon;
    ecl_ch.ecl_latitude  <= lat;
    do @(posedge clk); while (!ecl_ch.ready);
    pending_radec.push_back(equatorial_of(lon, lat));
    @(negedge clk);
  endtask

  task automatic maybe_pause_sender();
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      ecl_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] random_latitude();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'sh4000_0000 : -32'sh4000_0000;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      maybe_pause_sender();
      send_direction($urandom(), random_latitude());
    end
  endtask

  task automatic wait_drained();
    ecl_ch.valid <= 1'b0;
    while (pending_radec.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] lons [8];
    logic [31:0] lats [3];
    lons = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
             32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h2000_0000};
    lats = '{32'h0, 32'h4000_0000, 32'hC000_0000};
    foreach (lons[i]) send_direction(lons[i], lats[i % 3]);
    // latitudes at and beyond the poles and near zero, including the most negative encoding
    send_direction(32'h1234_5678, 32'h7FFF_FFFF);
    send_direction(32'h9ABC_DEF0, 32'h8000_0000);
    send_direction(32'h8000_0000, 32'hFFFF_FFFF);
    send_direction(32'hFFFF_FFFF, 32'h4000_0001);
    send_direction(32'h0, 32'hBFFF_FFFF);
    send_direction(32'h4000_0000, 32'h4000_0000);
    send_direction(32'hC000_0000, 32'hC000_0000);
    send_direction(32'h5555_5555, 32'hAAAA_AAAA);
    send_direction(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();
  endtask

  task automatic test_random_idling();
    send_random(700);
  endtask

  task automatic test_output_hold();
    hold_request = 400;
    send_random(300);
  endtask

  task automatic test_drain_pause();
    send_random(150);
    wait_drained();
    send_random(150);
  endtask

  task automatic test_full_rate();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    send_random(230);
    ecl_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    int hold_left, stall_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      eq_ch.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      eq_ch.ready <= 1'b0;
      stall_left--;
    end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
      eq_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      eq_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    radec_t want;
    if (!rst && eq_ch.valid && eq_ch.ready) begin
      if (pending_radec.size() == 0) begin
        $display("unexpected transaction: ra %h dec %h", eq_ch.right_ascension,
                 eq_ch.declination);
        errors++;
      end else begin
        want = pending_radec.pop_front();
        if (eq_ch.right_ascension !== want.ra)
          report_mismatch("right_ascension", eq_ch.right_ascension, want.ra);
        if (eq_ch.declination !== want.dec)
          report_mismatch("declination", eq_ch.declination, want.dec);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    ecl_ch.valid         = 1'b0;
    ecl_ch.ecl_longitude = '0;
    ecl_ch.ecl_latitude  = '0;
    eq_ch.ready          = 1'b1;
    build_atan_turns();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_idling();
    test_output_hold();
    test_drain_pause();
    test_full_rate();
    wait_drained();
    repeat (PIPE_DEPTH + 20) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[ecliptic_to_equatorial_j2000.f]
design/ecl2eq_pkg.sv
design/ecl2eq_if.sv
design/ecl2eq_rot.sv
design/ecl2eq_xform.sv
design/ecl2eq_vec.sv
design/ecliptic_to_equatorial_j2000.sv
sim/tb_top.sv
